>>> hw/rtl/mcs_pkg.sv
// Package for the Metropolis chain sampler: fixed-point widths, payload structs,
// sequencer state and multiplier operand codes, and the saturation helper.
// No dependencies.
package mcs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = FRAC_BITS + 1;  // values in [0, ONE]
	localparam int G_W       = FRAC_BITS + 2;  // g(t) below 2*ONE
	localparam int PROD_W    = 2 * G_W;        // shared multiplier product

	localparam logic [VAL_W-1:0] ONE        = VAL_W'(1) << FRAC_BITS;
	localparam logic [VAL_W-1:0] STEP_RESET = ONE >> 1;

	typedef struct packed {
		logic             restart;
		logic [VAL_W-1:0] u_step;
		logic [VAL_W-1:0] u_accept;
	} mcs_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] position;
		logic             accepted;
	} mcs_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_PROP,
		ST_SQ,
		ST_CUBE,
		ST_DONE
	} mcs_state_t;

	typedef enum logic [1:0] {
		MUL_MAG,
		MUL_SQ,
		MUL_CUBE,
		MUL_RATIO
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     ld_in;
		logic     ld_mag;
		logic     ld_prop;
		logic     ld_sq;
		logic     ld_gp;
		logic     finish;
	} mcs_ctl_t;

	function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
		return (v > ONE) ? ONE : v;
	endfunction

endpackage

>>> hw/rtl/mcs_ctrl.sv
// Sequencer for the Metropolis chain sampler: steps one item through the
// shared multiplier (offset, square, cube, ratio). Uses mcs_pkg.
module mcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             restart,
	input  logic             out_free,
	output logic             busy,
	output mcs_pkg::mcs_ctl_t ctl
);
	import mcs_pkg::*;

	mcs_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		ctl         = '0;
		ctl.mul_sel = MUL_MAG;
		busy        = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ctl.ld_in = 1'b1;
					// restart goes straight to evaluating g at the new position
					state_nxt = restart ? ST_SQ : ST_MAG;
				end
			end
			ST_MAG: begin
				ctl.mul_sel = MUL_MAG;
				ctl.ld_mag  = 1'b1;
				state_nxt   = ST_PROP;
			end
			ST_PROP: begin
				ctl.ld_prop = 1'b1;
				state_nxt   = ST_SQ;
			end
			ST_SQ: begin
				ctl.mul_sel = MUL_SQ;
				ctl.ld_sq   = 1'b1;
				state_nxt   = ST_CUBE;
			end
			ST_CUBE: begin
				ctl.mul_sel = MUL_CUBE;
				ctl.ld_gp   = 1'b1;
				state_nxt   = ST_DONE;
			end
			ST_DONE: begin
				ctl.mul_sel = MUL_RATIO;
				if (out_free) begin
					ctl.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/mcs_datapath.sv
// Datapath of the Metropolis chain sampler: input capture, the shared
// multiplier, proposal logic and chain state. Uses mcs_pkg.
module mcs_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mcs_pkg::mcs_ctl_t          ctl,
	input  mcs_pkg::mcs_item_t         item,
	input  logic [mcs_pkg::VAL_W-1:0]  step_size,
	output mcs_pkg::mcs_result_t       res
);
	import mcs_pkg::*;

	logic             rst_q, up_q, in_range_q;
	logic [VAL_W-1:0] u2_q, span_q, mag_q, t_q, sq_q, pos_q;
	logic [G_W-1:0]   gp_q, dens_q;

	logic [VAL_W-1:0] u1, prop, prod_hi;
	logic [VAL_W:0]   twice;
	logic             up, in_range, take;
	logic [G_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0] prod;

	assign u1    = sat_one(item.u_step);
	assign twice = {u1, 1'b0};
	assign up    = (twice >= {1'b0, ONE});

	// shared multiplier
	always_comb begin
		case (ctl.mul_sel)
			MUL_MAG: begin
				mul_a = {1'b0, span_q};
				mul_b = {1'b0, sat_one(step_size)};
			end
			MUL_SQ: begin
				mul_a = {1'b0, t_q};
				mul_b = {1'b0, t_q};
			end
			MUL_CUBE: begin
				mul_a = {1'b0, sq_q};
				mul_b = {1'b0, t_q};
			end
			MUL_RATIO: begin
				mul_a = {1'b0, u2_q};
				mul_b = dens_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign prod_hi = prod[FRAC_BITS +: VAL_W];

	always_comb begin
		if (up_q) begin
			in_range = (mag_q <= ONE - pos_q);
			prop     = pos_q + mag_q;
		end else begin
			in_range = (mag_q <= pos_q);
			prop     = pos_q - mag_q;
		end
	end

	// u2*g(x) <= g(p) scaled by ONE
	assign take = rst_q | (in_range_q & (prod <= PROD_W'({gp_q, {FRAC_BITS{1'b0}}})));

	assign res.position = take ? t_q : pos_q;
	assign res.accepted = take;

	always_ff @(posedge clk) begin
		if (ctl.ld_in) begin
			rst_q  <= item.restart;
			u2_q   <= sat_one(item.u_accept);
			up_q   <= up;
			span_q <= up ? VAL_W'(twice - {1'b0, ONE}) : VAL_W'({1'b0, ONE} - twice);
			t_q    <= u1;
		end
		if (ctl.ld_mag) begin
			mag_q <= prod_hi;
		end
		if (ctl.ld_prop) begin
			in_range_q <= in_range;
			t_q        <= prop;
		end
		if (ctl.ld_sq) begin
			sq_q <= prod_hi;
		end
		if (ctl.ld_gp) begin
			gp_q <= G_W'(ONE) + G_W'(t_q) - G_W'(prod_hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			dens_q <= G_W'(ONE);
		end else if (ctl.finish && take) begin
			pos_q  <= t_q;
			dens_q <= gp_q;
		end
	end

endmodule

>>> hw/rtl/metropolis_chain_sampler.sv
// Metropolis random-walk sampler for the density 0.8*(1 + x - x^3) on [0,1].
// Top level: config register, sequencer, datapath, result register.
// Depends on mcs_pkg, mcs_ctrl and mcs_datapath.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready/cfg_data) writes step_size, the proposal
//    half-width in Q1.16. cfg_ready is always high; write only while idle.
//  - item channel carries restart, u_step, u_accept. One item is in work at a
//    time; item_stall is high while it is.
//  - result channel carries the new position and an accept flag, one result
//    per item, held in an output register until transferred.
//  - Timing: after the transfer a chain step keeps the block busy through the
//    steps offset multiply, proposal, square, cube and ratio compare, and no
//    new item goes in until it is done; a restart skips the first two steps.
//    All of it is set by the single shared multiplier.
//  - The result appears in the cycle after the last busy cycle. If the receiver
//    stalls and the output register is still full, the sequencer waits in
//    its last step and input stays stalled.
//  - Reset: position 0, g = 1.0, step_size = 0.5, no result pending.
module metropolis_chain_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mcs_pkg::VAL_W-1:0]     cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  mcs_pkg::mcs_item_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output mcs_pkg::mcs_result_t          result
);
	import mcs_pkg::*;

	logic [VAL_W-1:0] step_q;
	logic             in_fire, out_free, busy;
	mcs_ctl_t         ctl;
	mcs_result_t      res, result_q;
	logic             result_valid_q;

	assign cfg_ready  = 1'b1;
	assign item_stall = busy;
	assign in_fire    = item_valid & ~busy;
	assign out_free   = ~result_valid_q | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	mcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.restart  (item.restart),
		.out_free (out_free),
		.busy     (busy),
		.ctl      (ctl)
	);

	mcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item      (item),
		.step_size (step_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> hw/rtl/mcs_checker.sv
// Port-level checks for metropolis_chain_sampler, attached by bind.
// Depends on mcs_pkg and the top level's ports.
module mcs_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input mcs_pkg::mcs_result_t result
);
	import mcs_pkg::*;

	// an accepted item occupies the block for the next cycle at least
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous one in work");

	// with no result pending, none shows up in the cycle right after an item transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !result_valid |=> !result_valid)
		else $error("result appeared too early");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.position <= ONE)
		else $error("position above one");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped under stall");

endmodule

bind metropolis_chain_sampler mcs_checker u_mcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> tb/sv/testbench.sv
// Testbench for metropolis_chain_sampler: directed and random chain steps,
// restarts and step_size settings. Results are checked against a local predictor.
// Depends on mcs_pkg and the metropolis_chain_sampler RTL.
`timescale 1ns / 100ps

module testbench;
	import mcs_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam logic [VAL_W-1:0] ALL_ONES = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [VAL_W-1:0]  cfg_data;
	logic              item_valid;
	logic              item_stall;
	mcs_item_t         item;
	logic              result_valid;
	logic              result_stall;
	mcs_result_t       result;

	// Predictor state
	logic [VAL_W-1:0]  chain_pos;
	logic [G_W-1:0]    chain_g;
	logic [VAL_W-1:0]  step_reg;

	mcs_result_t       pending[$];

	int unsigned errors, cycle_count;
	int unsigned items_sent, restarts_sent, results_seen, moves_taken, step_writes;
	bit          tx_quiet, rx_quiet;
	int unsigned rx_hold_request, rx_stall_left;

	metropolis_chain_sampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [VAL_W-1:0] clamp_unit(input logic [VAL_W-1:0] v);
		return (v > ONE) ? ONE : v;
	endfunction

	// g(t) = 1 + t - t^3 with truncated square and cube
	function automatic logic [G_W-1:0] density_g(input logic [VAL_W-1:0] t);
		logic [63:0] sq, cube;
		sq   = (64'(t) * 64'(t)) >> FRAC_BITS;
		cube = (sq * 64'(t)) >> FRAC_BITS;
		return G_W'(64'(ONE) + 64'(t) - cube);
	endfunction

	function automatic mcs_result_t chain_step(input mcs_item_t it);
		logic [VAL_W-1:0] u1, u2, delta, mag, prop;
		logic [G_W-1:0]   gp;
		logic [63:0]      twice, span;
		bit               up, fits;
		mcs_result_t      r;
		u1 = clamp_unit(it.u_step);
		u2 = clamp_unit(it.u_accept);
		r.accepted = 1'b0;
		if (it.restart) begin
			chain_pos = u1;
			chain_g = density_g(u1);
			r.accepted = 1'b1;
		end else begin
			delta = clamp_unit(step_reg);
			twice = 64'(u1) << 1;
			up = twice >= 64'(ONE);
			span = up ? twice - 64'(ONE) : 64'(ONE) - twice;
			mag = VAL_W'((span * 64'(delta)) >> FRAC_BITS);
			fits = up ? (mag <= ONE - chain_pos) : (mag <= chain_pos);
			if (fits) begin
				prop = up ? chain_pos + mag : chain_pos - mag;
				gp = density_g(prop);
				// compare u2 against g(p)/g(x) without dividing
				if (64'(u2) * 64'(chain_g) <= (64'(gp) << FRAC_BITS)) begin
					chain_pos = prop;
					chain_g = gp;
					r.accepted = 1'b1;
				end
			end
		end
		r.position = chain_pos;
		return r;
	endfunction

	function automatic mcs_item_t make_sample(input logic rs, input logic [VAL_W-1:0] u1,
		input logic [VAL_W-1:0] u2);
		mcs_item_t it;
		it.restart = rs;
		it.u_step = u1;
		it.u_accept = u2;
		return it;
	endfunction

	// Mostly in [0, ONE], now and then any 17-bit value
	function automatic logic [VAL_W-1:0] random_unit();
		if ($urandom_range(0, 9) == 0)
			return VAL_W'($urandom_range(0, int'(ALL_ONES)));
		return VAL_W'($urandom_range(0, int'(ONE)));
	endfunction

	task automatic send_sample(input mcs_item_t it);
		int unsigned gap;
		@(negedge clk);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		pending.push_back(chain_step(it));
		items_sent++;
		if (it.restart)
			restarts_sent++;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Sender goes quiet until every outstanding result has been transferred
	task automatic wait_chain_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_step_size(input logic [VAL_W-1:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		step_reg = value;
		step_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result receiver: random stall bursts, plus an occasional long hold
	always @(negedge clk) begin
		if (rx_hold_request != 0) begin
			rx_stall_left = rx_hold_request;
			rx_hold_request = 0;
		end else if (rx_stall_left == 0 && !rx_quiet && $urandom_range(0, 3) == 0) begin
			rx_stall_left = pick_gap();
		end
		result_stall <= (rx_stall_left != 0);
		if (rx_stall_left != 0)
			rx_stall_left--;
	end

	always @(posedge clk) begin : check_results
		mcs_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending.size() == 0) begin
				$error("result transfer with nothing expected: position %0d accepted %0b",
					result.position, result.accepted);
				errors++;
			end else begin
				want = pending.pop_front();
				if (result.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, result.position);
					errors++;
				end
				if (result.accepted !== want.accepted) begin
					$error("accepted: expected %0b, got %0b", want.accepted, result.accepted);
					errors++;
				end
				if (want.accepted)
					moves_taken++;
			end
		end
	end

	task automatic test_restart_edges();
		send_sample(make_sample(1'b1, '0, 17'd777));
		send_sample(make_sample(1'b1, ONE, '0));
		send_sample(make_sample(1'b1, ALL_ONES, ONE));
		send_sample(make_sample(1'b1, ONE >> 1, ALL_ONES));
		send_sample(make_sample(1'b1, 17'd12345, 17'd40000));
	endtask

	// Default step_size (half); walks to both ends of [0,1] and past them
	task automatic test_step_edges();
		send_sample(make_sample(1'b1, ONE >> 1, '0));
		send_sample(make_sample(1'b0, ONE, '0));        // lands exactly on one
		send_sample(make_sample(1'b0, ONE, '0));        // past one, rejected
		send_sample(make_sample(1'b0, ALL_ONES, '0));   // saturates, still past one
		send_sample(make_sample(1'b0, ONE >> 1, ONE));  // zero offset
		send_sample(make_sample(1'b0, '0, '0));
		send_sample(make_sample(1'b0, '0, '0));         // lands exactly on zero
		send_sample(make_sample(1'b0, '0, '0));         // below zero, rejected
		send_sample(make_sample(1'b0, (ONE >> 1) + 1, ONE));
		send_sample(make_sample(1'b0, 17'd49152, ALL_ONES));
		send_sample(make_sample(1'b1, 17'd58982, '0));
		send_sample(make_sample(1'b0, 17'd60000, ONE)); // past one, rejected
	endtask

	task automatic test_step_size_extremes();
		wait_chain_idle();
		write_step_size('0);
		send_sample(make_sample(1'b0, '0, ONE));
		send_sample(make_sample(1'b0, ONE, ALL_ONES));
		wait_chain_idle();
		write_step_size(ONE);
		send_sample(make_sample(1'b1, ONE >> 1, '0));
		send_sample(make_sample(1'b0, ONE, '0));
		wait_chain_idle();
		write_step_size(ALL_ONES);
		send_sample(make_sample(1'b0, '0, 17'd30000));
	endtask

	// Receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		wait_chain_idle();
		write_step_size(17'd20000);
		rx_hold_request = 80;
		tx_quiet = 1'b1;
		send_sample(make_sample(1'b1, 17'd30000, '0));
		repeat (9)
			send_sample(make_sample(1'b0, random_unit(), random_unit()));
		tx_quiet = 1'b0;
		wait_chain_idle();
	endtask

	task automatic test_random_walk();
		logic [VAL_W-1:0] sizes[7];
		sizes = '{STEP_RESET, 17'd1, 17'd2048, ONE, ALL_ONES, 17'd0, 17'd300};
		sizes[5] = VAL_W'($urandom_range(1, int'(ONE)));
		for (int p = 0; p < 7; p++) begin
			wait_chain_idle();
			write_step_size(sizes[p]);
			tx_quiet = (p == 2);
			rx_quiet = (p == 2);
			for (int n = 0; n < 60; n++) begin
				if (p == 4 && n == 30)
					wait_chain_idle();
				send_sample(make_sample($urandom_range(0, 99) < 8, random_unit(),
					random_unit()));
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		chain_pos = '0;
		chain_g = G_W'(ONE);
		step_reg = STEP_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_restart_edges();
		test_step_edges();
		test_step_size_extremes();
		test_backpressure();
		test_random_walk();
		wait_chain_idle();

		$display("%0d items (%0d restarts) under %0d step_size writes, %0d results checked",
			items_sent, restarts_sent, step_writes, results_seen);
		$display("%0d results moved or restarted the chain, %0d cycles", moves_taken,
			cycle_count);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
